// ----- hw/rtl/spq_pkg.sv -----
package spq_pkg;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  prio;
  } entry_t;

endpackage

// ----- hw/rtl/sorted_priority_queue.sv -----
// sorted list queue in one ring memory with one write and one read port; an insert reads
// each entry it passes (INS_RD), then compares it and moves it one place (INS_CMP)
// refused insert or remove on empty: result word in the cycle after acceptance;
// a remove passes REM_RD and REM_TAKE; the next word is taken in the cycle after the result
// word leaves; an insert scans stored entries from the tail through the memory read port
// synchronous reset clears count, head pointer and sequencer; entry memory is not cleared
module sorted_priority_queue #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [15:0] item_id,
  input  logic [7:0]  priority_req,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [15:0] removed_id,
  output logic [7:0]  removed_priority,
  output logic [4:0]  occupancy
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    IDLE, INS_RD, INS_CMP, INS_PUT, REM_RD, REM_TAKE, RESULT
  } state_t;

  state_t             state;
  logic [CW-1:0]      count;
  logic [CW-1:0]      k;
  logic [AW-1:0]      head;
  spq_pkg::entry_t    new_ent;
  spq_pkg::entry_t    rd_data;
  spq_pkg::entry_t    wr_data;
  spq_pkg::entry_t    mem [DEPTH];

  logic [CW-1:0]      km1;
  logic [AW:0]        sum_k;
  logic [AW:0]        sum_km1;
  logic [AW-1:0]      p_k;
  logic [AW-1:0]      p_km1;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      head_next;
  logic               wr_en;
  logic               greater;

  // logical position to ring address
  always_comb begin
    km1     = k - CW'(1);
    sum_k   = {1'b0, head} + {1'b0, k[AW-1:0]};
    sum_km1 = {1'b0, head} + {1'b0, km1[AW-1:0]};
    p_k     = (sum_k >= (AW+1)'(DEPTH)) ? AW'(sum_k - (AW+1)'(DEPTH)) : sum_k[AW-1:0];
    p_km1   = (sum_km1 >= (AW+1)'(DEPTH)) ? AW'(sum_km1 - (AW+1)'(DEPTH))
                                          : sum_km1[AW-1:0];
    head_next = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
    greater = rd_data.prio > new_ent.prio;
    rd_addr = (state == REM_RD) ? head : p_km1;
    wr_en   = (state == INS_CMP) || (state == INS_PUT);
    // an entry of higher value moves one place towards the tail
    wr_data = ((state == INS_CMP) && greater) ? rd_data : new_ent;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[p_k] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  assign in_stall = (state != IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      count     <= '0;
      head      <= '0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (in_valid) begin
            new_ent.id   <= item_id;
            new_ent.prio <= priority_req;
            removed_id       <= '0;
            removed_priority <= '0;
            occupancy        <= 5'(count);
            if (action == spq_pkg::ACT_INSERT) begin
              if (count == CW'(DEPTH)) begin
                status    <= spq_pkg::ST_FULL;
                out_valid <= 1'b1;
                state     <= RESULT;
              end else begin
                k     <= count;
                state <= (count == '0) ? INS_PUT : INS_RD;
              end
            end else begin
              if (count == '0) begin
                status    <= spq_pkg::ST_EMPTY;
                out_valid <= 1'b1;
                state     <= RESULT;
              end else begin
                state <= REM_RD;
              end
            end
          end
        end
        INS_RD: begin
          state <= INS_CMP;
        end
        INS_CMP: begin
          if (greater) begin
            k     <= km1;
            state <= (k == CW'(1)) ? INS_PUT : INS_RD;
          end else begin
            count     <= count + CW'(1);
            occupancy <= 5'(count + CW'(1));
            status    <= spq_pkg::ST_DONE;
            out_valid <= 1'b1;
            state     <= RESULT;
          end
        end
        INS_PUT: begin
          count     <= count + CW'(1);
          occupancy <= 5'(count + CW'(1));
          status    <= spq_pkg::ST_DONE;
          out_valid <= 1'b1;
          state     <= RESULT;
        end
        REM_RD: begin
          state <= REM_TAKE;
        end
        REM_TAKE: begin
          removed_id       <= rd_data.id;
          removed_priority <= rd_data.prio;
          head             <= head_next;
          count            <= count - CW'(1);
          occupancy        <= 5'(count - CW'(1));
          status           <= spq_pkg::ST_DONE;
          out_valid        <= 1'b1;
          state            <= RESULT;
        end
        RESULT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
